[rtl/plen_pkg.sv]
package plen_pkg;

  // List geometry.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Widths of the transaction fields.
  localparam int OP_W   = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 9;
  localparam int STAT_W = 2;
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // Opcodes carried by an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 4'd0,
    OP_INS_POS   = 4'd1,
    OP_INS_LAST  = 4'd2,
    OP_DEL_FIRST = 4'd3,
    OP_DEL_POS   = 4'd4,
    OP_DEL_LAST  = 4'd5,
    OP_READ_FWD  = 4'd6,
    OP_READ_BWD  = 4'd7,
    OP_SIZE      = 4'd8,
    OP_CLEAR     = 4'd9
  } plen_op_e;

  // Status codes of a result.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } plen_status_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } plen_state_e;

  // Operation that every cell applies to its entry.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROTL,
    CELL_ROTR
  } plen_cell_op_e;

  // Command broadcast to the row of cells.
  typedef struct packed {
    plen_cell_op_e            op;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         last;
    logic signed [VAL_W-1:0]  value;
    logic signed [VAL_W-1:0]  head;
    logic signed [VAL_W-1:0]  tail;
  } plen_cell_cmd_t;

endpackage

[rtl/plen_in_if.sv]
interface plen_in_if;
  import plen_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [VAL_W-1:0] item_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, output opcode, output item_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input item_value, input position,
                  output ready);
endinterface

[rtl/plen_out_if.sv]
interface plen_out_if;
  import plen_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic [STAT_W-1:0]       status;
  logic [CNT_W-1:0]        entry_count;
  logic                    last_of_run;

  modport source (output valid, output out_value, output status, output entry_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_value, input status, input entry_count,
                  input last_of_run, output ready);
endinterface

[rtl/plen_cell.sv]
module plen_cell (
  input  logic                            clk_i,
  input  logic [plen_pkg::IDX_W-1:0]      cell_idx_i,
  input  plen_pkg::plen_cell_cmd_t        cmd_i,
  input  logic signed [plen_pkg::VAL_W-1:0] left_i,
  input  logic signed [plen_pkg::VAL_W-1:0] right_i,
  output logic signed [plen_pkg::VAL_W-1:0] val_o
);
  import plen_pkg::*;

  logic signed [VAL_W-1:0] val_q;
  logic signed [VAL_W-1:0] val_d;

  // Pick the new value from this cell, a neighbor or the broadcast.
  always_comb begin
    val_d = val_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (cell_idx_i == cmd_i.idx) begin
          val_d = cmd_i.value;
        end else if (cell_idx_i > cmd_i.idx) begin
          val_d = left_i;
        end
      end
      CELL_DEL: begin
        if (cell_idx_i >= cmd_i.idx) begin
          val_d = right_i;
        end
      end
      CELL_ROTL: begin
        if (cell_idx_i == cmd_i.last) begin
          val_d = cmd_i.head;
        end else if (cell_idx_i < cmd_i.last) begin
          val_d = right_i;
        end
      end
      CELL_ROTR: begin
        if (cell_idx_i == '0) begin
          val_d = cmd_i.tail;
        end else if (cell_idx_i <= cmd_i.last) begin
          val_d = left_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  // The entry itself needs no reset.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[rtl/positional_list_engine.sv]
// Ordered list of up to CAPACITY signed 32-bit values, kept in a row of cells.
// The in_i channel takes one transaction per operation: opcode, item_value
// and a one-based position. The out_o channel returns results; the last
// result of an operation has last_of_run set.
// Inserts, deletes, size, clear and unused opcodes give one result, which
// appears in the output register in the cycle after acceptance; the edit
// shifts the cells from its position up at that edge, so such operations
// sustain one per cycle while the receiver keeps up. A forward or backward
// read of N entries gives N results, one per cycle while the receiver takes
// them, from the read state on; the list rotates once through the cells and
// ends in its original order. No new transaction is taken until a read's last
// result is registered. A read of an empty list gives one empty result.
// When the receiver stalls, the output register holds its result and the
// input stops accepting until the register can take the next one.
// Reset empties the list and drops any pending result; there is no
// clearing pass, and entries are only read below the entry count.
module positional_list_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  plen_in_if.sink    in_i,
  plen_out_if.source out_o
);
  import plen_pkg::*;

  plen_state_e             state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic                    dir_q, dir_d;
  logic                    ov_q, ov_d;
  logic signed [VAL_W-1:0] oval_q, oval_d;
  logic [STAT_W-1:0]       ost_q, ost_d;
  logic [CNT_W-1:0]        ocnt_q, ocnt_d;
  logic                    olast_q, olast_d;

  plen_cell_cmd_t          cmd;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [IDX_W-1:0]        sel_idx;
  logic signed [VAL_W-1:0] sel_val;
  logic [IDX_W-1:0]        last_idx;
  logic [IDX_W-1:0]        pos_idx;
  logic [CMP_W-1:0]        pos_x;
  logic [CMP_W-1:0]        cnt_x;
  logic                    slot_free;
  logic                    in_ready;
  logic                    in_acc;
  plen_op_e                op;

  // Row of cells; at the ends a missing neighbor link comes from the cell itself.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_val[g];
    end else begin : g_mid_l
      assign left_w = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_val[g];
    end else begin : g_mid_r
      assign right_w = cell_val[g+1];
    end
    plen_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .cmd_i      (cmd),
      .left_i     (left_w),
      .right_i    (right_w),
      .val_o      (cell_val[g])
    );
  end

  // Shared helpers for position checks and the selected entry.
  assign last_idx  = IDX_W'(cnt_q - CNT_W'(1));
  assign pos_idx   = IDX_W'(in_i.position - POS_W'(1));
  assign pos_x     = CMP_W'(in_i.position);
  assign cnt_x     = CMP_W'(cnt_q);
  assign sel_val   = cell_val[sel_idx];
  assign op        = plen_op_e'(in_i.opcode);
  assign slot_free = !ov_q || out_o.ready;
  assign in_ready  = (state_q == ST_IDLE) && slot_free;
  assign in_acc    = in_i.valid && in_ready;

  // Sequencer: edits apply at acceptance, reads stream by rotating the cells.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dir_d     = dir_q;
    ov_d      = ov_q && !out_o.ready;
    oval_d    = oval_q;
    ost_d     = ost_q;
    ocnt_d    = ocnt_q;
    olast_d   = olast_q;
    sel_idx   = last_idx;
    cmd.op    = CELL_HOLD;
    cmd.idx   = '0;
    cmd.last  = last_idx;
    cmd.value = in_i.item_value;
    cmd.head  = cell_val[0];
    cmd.tail  = sel_val;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ov_d    = 1'b1;
          oval_d  = '0;
          ost_d   = STAT_OK;
          olast_d = 1'b1;
          case (op)
            OP_INS_FIRST, OP_INS_POS, OP_INS_LAST: begin
              if (op == OP_INS_POS &&
                  (pos_x == '0 || pos_x > cnt_x + CMP_W'(1))) begin
                ost_d = STAT_BADPOS;
              end else if (cnt_q >= CNT_W'(CAPACITY)) begin
                ost_d = STAT_FULL;
              end else begin
                cmd.op = CELL_INS;
                if (op == OP_INS_FIRST) begin
                  cmd.idx = '0;
                end else if (op == OP_INS_LAST) begin
                  cmd.idx = IDX_W'(cnt_q);
                end else begin
                  cmd.idx = pos_idx;
                end
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            OP_DEL_FIRST, OP_DEL_POS, OP_DEL_LAST: begin
              if (cnt_q == '0) begin
                ost_d = STAT_EMPTY;
              end else if (op == OP_DEL_POS && (pos_x == '0 || pos_x > cnt_x)) begin
                ost_d = STAT_BADPOS;
              end else begin
                if (op == OP_DEL_FIRST) begin
                  sel_idx = '0;
                end else if (op == OP_DEL_LAST) begin
                  sel_idx = last_idx;
                end else begin
                  sel_idx = pos_idx;
                end
                cmd.op  = CELL_DEL;
                cmd.idx = sel_idx;
                oval_d  = sel_val;
                cnt_d   = cnt_q - CNT_W'(1);
              end
            end
            OP_READ_FWD, OP_READ_BWD: begin
              if (cnt_q == '0) begin
                ost_d = STAT_EMPTY;
              end else begin
                ov_d    = ov_q && !out_o.ready;
                oval_d  = oval_q;
                olast_d = olast_q;
                ost_d   = ost_q;
                dir_d   = (op == OP_READ_BWD);
                rem_d   = cnt_q;
                state_d = ST_READ;
              end
            end
            OP_CLEAR: cnt_d = '0;
            default: ;
          endcase
          if (state_d == ST_IDLE) begin
            ocnt_d = cnt_d;
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          oval_d  = dir_q ? sel_val : cell_val[0];
          ost_d   = STAT_OK;
          ocnt_d  = cnt_q;
          olast_d = (rem_q == CNT_W'(1));
          cmd.op  = dir_q ? CELL_ROTR : CELL_ROTL;
          rem_d   = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      dir_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      dir_q   <= dir_d;
      ov_q    <= ov_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    oval_q  <= oval_d;
    ost_q   <= ost_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = ov_q;
  assign out_o.out_value   = oval_q;
  assign out_o.status      = ost_q;
  assign out_o.entry_count = ocnt_q;
  assign out_o.last_of_run = olast_q;

  // The entry count never exceeds the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // During a read the remaining count is nonzero and within the list.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> rem_q != '0 && rem_q <= cnt_q)
    else $error("read counter out of range");

  // A read of a non-empty list enters the streaming state.
  a_read_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op == OP_READ_FWD || op == OP_READ_BWD) && cnt_q != '0
    |=> state_q == ST_READ)
    else $error("read did not start");

  // The list size does not change while a read streams.
  a_read_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> $stable(cnt_q))
    else $error("entry count changed during read");

endmodule
